@@ rtl/core/integer_to_ascii_formatter_top_assert.svh @@
// Assertion macros shared by the integer to ASCII formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ITAF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("itaf assertion failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ITAF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("itaf assertion failed");
`else
`define ITAF_ASSERT_IMPL(lbl, ante, cons)
`define ITAF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/itaf_pkg.sv @@
// Shared types, codes and character tables of the integer to ASCII formatter.
`timescale 1ns / 1ps

package itaf_pkg;

    // Operation codes
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_LHEX = 3'd2;
    localparam logic [2:0] OP_UHEX = 3'd3;
    localparam logic [2:0] OP_PTR  = 3'd4;

    // Reciprocal of ten: q = (v * DIV10_RECIP) >> DIV10_SHIFT is exact for 32-bit v
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          QUOT10_W    = 64 - DIV10_SHIFT;

    localparam int MAX_DIGITS = 16;
    localparam int MAX_DEC    = 10;

    typedef enum logic [1:0] {
        PRE_NONE  = 2'd0,
        PRE_MINUS = 2'd1,
        PRE_HEX   = 2'd2,
        PRE_NIL   = 2'd3
    } t_prefix;

    // Request to the digit unit
    typedef struct packed {
        logic        start;
        logic        hex;
        logic [63:0] value;
    } t_unit_req;

    // Result of the digit unit
    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [3:0]  digit;
    } t_unit_rsp;

    function automatic logic [2:0] prefix_len(input t_prefix kind);
        case (kind)
            PRE_MINUS: prefix_len = 3'd1;
            PRE_HEX:   prefix_len = 3'd2;
            PRE_NIL:   prefix_len = 3'd5;
            default:   prefix_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] prefix_char(input t_prefix kind, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h30;
        case (kind)
            PRE_MINUS: c = 8'h2D;
            PRE_HEX:   c = (idx == 3'd0) ? 8'h30 : 8'h78;
            PRE_NIL: begin
                case (idx)
                    3'd0:    c = 8'h28;
                    3'd1:    c = 8'h6E;
                    3'd2:    c = 8'h69;
                    3'd3:    c = 8'h6C;
                    default: c = 8'h29;
                endcase
            end
            default:   c = 8'h30;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'b0, d};
        end else begin
            c = (upper ? 8'h41 : 8'h61) + {4'b0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

@@ rtl/core/integer_to_ascii_formatter_top.sv @@
// Top level of the integer to ASCII formatter: sequencer, digit store and output stage.
//
// Usage: an item enters on the s_axis channel (tuser = operation, tdata = number)
// and its text leaves on m_axis, one ASCII character per transfer, most
// significant first, with tlast on the final character. Operation codes 5 to 7
// produce no characters.
// Digits come from one shared unit that splits off one digit per request
// (multiply by the reciprocal of ten, or a 4-bit shift for hex), with the
// S_CONV and S_WAIT states for each: up to 10 decimal digits, or 16 for a
// pointer. The characters then follow, one per cycle while m_axis_tready is high.
// s_axis_tready is high only while the block waits for an item; the last
// character sits in the output register, so a new item can be taken while it
// waits. When the receiver stalls, output holds and the sequencer waits.
// Reset (synchronous, active low) empties the output register and returns to
// the wait state; no character is in flight afterward.
`timescale 1ns / 1ps

`include "integer_to_ascii_formatter_top_assert.svh"

module integer_to_ascii_formatter_top
    import itaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] number
    input  logic [2:0]  s_axis_tuser,   // [2:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] character
    output logic        m_axis_tlast
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_WAIT = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [63:0] r_val;
    logic        r_hex;
    logic        r_upper;
    t_prefix     r_prefix;
    logic [2:0]  r_npre;
    logic [4:0]  r_ndig;
    logic [4:0]  r_pos;
    logic [3:0]  r_dig [MAX_DIGITS];
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;

    logic        w_in_acc;
    logic        w_op_ok;
    logic        w_hex;
    logic        w_upper;
    t_prefix     w_prefix;
    logic [63:0] w_val;
    logic [31:0] w_low;
    logic        w_load;
    logic [4:0]  w_len;
    logic        w_is_pre;
    logic [4:0]  w_rd_idx;
    logic [7:0]  w_char;
    logic        w_last;
    t_unit_req   w_req;
    t_unit_rsp   w_rsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_low         = s_axis_tdata[31:0];

    // Decode the operation into value, prefix and digit set
    always_comb begin
        w_op_ok  = 1'b1;
        w_hex    = 1'b0;
        w_upper  = 1'b0;
        w_prefix = PRE_NONE;
        w_val    = {32'b0, w_low};
        case (s_axis_tuser)
            OP_SDEC: begin
                if (w_low[31]) begin
                    w_prefix = PRE_MINUS;
                    w_val    = {32'b0, 32'd0 - w_low};
                end
            end
            OP_UDEC: w_op_ok = 1'b1;
            OP_LHEX: w_hex = 1'b1;
            OP_UHEX: begin
                w_hex   = 1'b1;
                w_upper = 1'b1;
            end
            OP_PTR: begin
                w_hex    = 1'b1;
                w_val    = s_axis_tdata;
                w_prefix = (s_axis_tdata == 64'd0) ? PRE_NIL : PRE_HEX;
            end
            default: w_op_ok = 1'b0;
        endcase
    end

    // Shared digit unit
    assign w_req.start = (r_state == S_CONV);
    assign w_req.hex   = r_hex;
    assign w_req.value = r_val;

    itaf_digit_unit u_digit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Select the character at the current position
    assign w_len    = {2'b0, r_npre} + r_ndig;
    assign w_is_pre = (r_pos < {2'b0, r_npre});
    assign w_rd_idx = r_ndig - 5'd1 - (r_pos - {2'b0, r_npre});
    assign w_char   = w_is_pre ? prefix_char(r_prefix, r_pos[2:0])
                               : digit_char(r_dig[w_rd_idx[3:0]], r_upper);
    assign w_last   = (r_pos == w_len - 5'd1);
    assign w_load   = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);

    // Sequence conversion and output
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_op_ok) begin
                    n_state = (w_prefix == PRE_NIL) ? S_EMIT : S_CONV;
                end
            end
            S_CONV: n_state = S_WAIT;
            S_WAIT: n_state = (w_rsp.quot == 64'd0) ? S_EMIT : S_CONV;
            S_EMIT: begin
                if (w_load && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ndig      <= 5'd0;
            r_pos       <= 5'd0;
        end else begin
            r_state <= n_state;
            // Latch the decoded item
            if (w_in_acc) begin
                r_val    <= w_val;
                r_hex    <= w_hex;
                r_upper  <= w_upper;
                r_prefix <= w_prefix;
                r_npre   <= prefix_len(w_prefix);
                r_ndig   <= 5'd0;
                r_pos    <= 5'd0;
            end
            // Store one digit, advance the value
            if (r_state == S_WAIT) begin
                r_dig[r_ndig[3:0]] <= w_rsp.digit;
                r_ndig             <= r_ndig + 5'd1;
                r_val              <= w_rsp.quot;
            end
            // Drop the output once taken, load the next character
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_char  <= w_char;
                r_out_last  <= w_last;
                r_pos       <= r_pos + 5'd1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

    `ITAF_ASSERT_IMPL(a_wait_has_digit, r_state == S_WAIT, w_rsp.done)
    `ITAF_ASSERT_IMPL(a_digit_count, 1'b1, r_ndig <= 5'(MAX_DIGITS))
    `ITAF_ASSERT_IMPL(a_dec_count, (r_state == S_EMIT) && !r_hex, r_ndig <= 5'(MAX_DEC))
    `ITAF_ASSERT_NEXT(a_bad_op_idle, w_in_acc && !w_op_ok, r_state == S_IDLE)
    `ITAF_ASSERT_NEXT(a_good_op_busy, w_in_acc && w_op_ok, r_state != S_IDLE)

endmodule

@@ rtl/core/itaf_digit_unit.sv @@
// Shared digit unit: one decimal or hex digit split off a value per request.
`timescale 1ns / 1ps

module itaf_digit_unit
    import itaf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    logic                r_busy;
    logic                r_hex;
    logic [63:0]         r_val;
    logic [63:0]         r_prod;
    logic [63:0]         w_prod;
    logic [QUOT10_W-1:0] w_q10;
    logic [31:0]         w_q10x;
    logic [31:0]         w_rem;

    // Multiply by the reciprocal of ten on request
    assign w_prod = 64'(i_req.value[31:0]) * 64'(DIV10_RECIP);

    // Register operand and product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_req.start;
        end
        if (i_req.start) begin
            r_hex  <= i_req.hex;
            r_val  <= i_req.value;
            r_prod <= w_prod;
        end
    end

    // Quotient and remainder from the registered product
    assign w_q10  = r_prod[63:DIV10_SHIFT];
    assign w_q10x = {w_q10, 3'b000} + {2'b00, w_q10, 1'b0};
    assign w_rem  = r_val[31:0] - w_q10x;

    assign o_rsp.done  = r_busy;
    assign o_rsp.quot  = r_hex ? {4'b0, r_val[63:4]} : {{DIV10_SHIFT{1'b0}}, w_q10};
    assign o_rsp.digit = r_hex ? r_val[3:0] : w_rem[3:0];

endmodule

@@ tb/sv/integer_to_ascii_formatter_checker.sv @@
// Scoreboard for the integer to ASCII formatter: predicts the text of each number and checks it.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_checker
    import itaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] number
    input  logic [2:0]  s_axis_tuser,   // [2:0] operation
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] character
    input  logic        m_axis_tlast,
    output int          o_mismatch_count,
    output int          o_chars_outstanding
);

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_text_char;

    // Characters still owed by the block, oldest first
    t_text_char owed_text[$];
    t_text_char owed;

    // Print one line per mismatch (up to a cap) and count every one
    task automatic report_mismatch(input string msg);
        if (o_mismatch_count < MAX_REPORTS) begin
            $display("%0t ns: mismatch: %0s", $realtime, msg);
        end
        o_mismatch_count++;
    endtask

    // Build the expected text of one number and append it to the owed characters
    function automatic void append_text(input logic [2:0] op, input logic [63:0] num);
        logic [7:0]  text[$];
        logic [31:0] low;
        logic [31:0] dec;
        logic [63:0] hex;
        logic        negative;
        string       digits;
        string       nil_text;
        low      = num[31:0];
        negative = (op == OP_SDEC) && low[31];
        dec      = negative ? (32'd0 - low) : low;
        hex      = (op == OP_PTR) ? num : {32'd0, low};
        digits   = (op == OP_UHEX) ? "0123456789ABCDEF" : "0123456789abcdef";
        nil_text = "(nil)";
        case (op)
            OP_SDEC, OP_UDEC: begin
                // peel off decimal digits, least significant first
                do begin
                    text.push_front(8'("0") + 8'(dec % 32'd10));
                    dec = dec / 32'd10;
                end while (dec != 32'd0);
                if (negative) begin
                    text.push_front("-");
                end
            end
            OP_LHEX, OP_UHEX, OP_PTR: begin
                if (op == OP_PTR && num == 64'd0) begin
                    for (int i = 0; i < nil_text.len(); i++) begin
                        text.push_back(nil_text[i]);
                    end
                end else begin
                    // peel off nibbles, no leading zeros
                    do begin
                        text.push_front(digits[hex[3:0]]);
                        hex = hex >> 4;
                    end while (hex != 64'd0);
                    if (op == OP_PTR) begin
                        text.push_front("x");
                        text.push_front("0");
                    end
                end
            end
            default: ;  // spare codes print nothing
        endcase
        foreach (text[i]) begin
            owed_text.push_back('{code: text[i], last: (i == text.size() - 1)});
        end
    endfunction

    // Compare each output transfer, then record each input transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            owed_text.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_text.size() == 0) begin
                    report_mismatch($sformatf("character %02h with no text owed", m_axis_tdata));
                end else begin
                    owed = owed_text.pop_front();
                    if (m_axis_tdata !== owed.code) begin
                        report_mismatch($sformatf("character %02h, wanted %02h",
                                                  m_axis_tdata, owed.code));
                    end
                    if (m_axis_tlast !== owed.last) begin
                        report_mismatch($sformatf("tlast %b on %02h, wanted %b",
                                                  m_axis_tlast, m_axis_tdata, owed.last));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                append_text(s_axis_tuser, s_axis_tdata);
            end
        end
        o_chars_outstanding = owed_text.size();
    end

endmodule

@@ tb/sv/integer_to_ascii_formatter_top_test.sv @@
// Top of the integer to ASCII formatter regression: clock, reset, traffic and verdict.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top_test
    import itaf_pkg::*;
();

    // Codes with no format behind them
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int NUMBER_COUNT  = 436;
    localparam int IDLE_PCT      = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int LIMIT_CYCLES  = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [63:0] number
    logic [2:0]  s_axis_tuser;   // [2:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] character
    logic        m_axis_tlast;

    int   mismatch_count;
    int   chars_outstanding;
    int   cycle_count;
    logic no_idle_stretch;
    logic hold_request;

    integer_to_ascii_formatter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    integer_to_ascii_formatter_checker scoreboard (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tlast        (m_axis_tlast),
        .o_mismatch_count    (mismatch_count),
        .o_chars_outstanding (chars_outstanding)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drive the output ready: random stalls, quiet stretches and one long hold-off
    initial begin
        int   hold_left;
        logic hold_taken;
        hold_left     = 0;
        hold_taken    = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = no_idle_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Offer one number, with an optional idle gap first; returns at the falling
    // edge after the transfer with tvalid still high
    task automatic offer_number(input logic [2:0] op, input logic [63:0] num);
        while (!no_idle_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = num;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering until every owed character has come out
    task automatic wait_for_drain();
        s_axis_tvalid = 1'b0;
        while (chars_outstanding != 0) @(negedge i_clk);
    endtask

    // Pick a number that favors digit-count and sign boundaries
    function automatic logic [63:0] pick_number();
        logic [63:0] n;
        logic [31:0] p;
        case ($urandom_range(0, 5))
            0: n = {$urandom, $urandom};
            1: n = 64'($urandom_range(0, 20));
            2: n = {$urandom, $urandom} >> $urandom_range(0, 63);
            3: begin
                case ($urandom_range(0, 3))
                    0:       p = 32'h8000_0000;
                    1:       p = 32'h7FFF_FFFF;
                    2:       p = 32'hFFFF_FFFF;
                    default: p = 32'h0000_0000;
                endcase
                n = {$urandom, p};
            end
            4: begin
                // around a power of ten
                p = 32'd1;
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                n = {$urandom, p + 32'($urandom_range(0, 2)) - 32'd1};
            end
            default: begin
                // around a nibble boundary, full width
                n = (64'd1 << (4 * $urandom_range(0, 15))) - 64'($urandom_range(0, 1));
            end
        endcase
        return n;
    endfunction

    // Reset, directed numbers, then random traffic and the verdict
    initial begin
        logic [2:0]  op;
        logic [63:0] num;
        int          made;
        logic        hold_done;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tuser    = OP_SDEC;
        s_axis_tdata    = 64'd0;
        no_idle_stretch = 1'b0;
        hold_request    = 1'b0;
        hold_done       = 1'b0;
        made            = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // signed decimal: zero, extremes, most negative, high bits ignored
        offer_number(OP_SDEC, 64'd0);
        offer_number(OP_SDEC, 64'h0000_0000_7FFF_FFFF);
        offer_number(OP_SDEC, 64'h0000_0000_8000_0000);
        offer_number(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_number(OP_SDEC, 64'hFFFF_FFFF_0000_0005);
        // unsigned decimal
        offer_number(OP_UDEC, 64'd0);
        offer_number(OP_UDEC, 64'h0000_0000_FFFF_FFFF);
        offer_number(OP_UDEC, 64'hA5A5_A5A5_4996_02D2);
        offer_number(OP_UDEC, 64'h0000_0000_8000_0000);
        // hex, both cases
        offer_number(OP_LHEX, 64'd0);
        offer_number(OP_LHEX, 64'hFFFF_FFFF_DEAD_BEEF);
        offer_number(OP_LHEX, 64'h0000_0000_FFFF_FFFF);
        offer_number(OP_UHEX, 64'h1234_5678_ABCD_EF01);
        offer_number(OP_UHEX, 64'hFFFF_FFFF_0000_0000);
        offer_number(OP_UHEX, 64'h0000_0000_0000_000A);
        // pointer: null, smallest, full width, zero low half
        offer_number(OP_PTR, 64'd0);
        offer_number(OP_PTR, 64'd1);
        offer_number(OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_number(OP_PTR, 64'h0000_0001_0000_0000);
        offer_number(OP_PTR, 64'h8000_0000_0000_0000);
        offer_number(OP_PTR, 64'h0123_4567_89AB_CDEF);
        // spare codes print nothing
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
            offer_number(3'(c), {$urandom, $urandom});
        end
        wait_for_drain();

        // random traffic
        while (made < NUMBER_COUNT) begin
            if (made == 90 || made == 370) begin
                wait_for_drain();
            end
            no_idle_stretch = (made >= 180 && made < 260);
            if (made == 300 && !hold_done) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if ($urandom_range(0, 99) < 8) begin
                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            end else begin
                op = 3'($urandom_range(OP_SDEC, OP_PTR));
            end
            num = pick_number();
            offer_number(op, num);
            made++;
        end
        no_idle_stretch = 1'b0;

        // let the last text drain, then settle
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ integer_to_ascii_formatter_top.f @@
+incdir+rtl/core
rtl/core/itaf_pkg.sv
rtl/core/itaf_digit_unit.sv
rtl/core/integer_to_ascii_formatter_top.sv
tb/sv/integer_to_ascii_formatter_checker.sv
tb/sv/integer_to_ascii_formatter_top_test.sv
